@@ sv/fle_pkg.sv @@
// fle_pkg: shared types and constants of the fill level estimator.
// Holds the controller/datapath command and status structs and field widths.
// No dependencies.
`default_nettype none

package fle_pkg;

	// Field widths of the stream words and registers
	localparam int DIST_W  = 10;
	localparam int FILL_W  = 7;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [DIST_W-1:0] DIST_MAX   = 10'd1023;
	localparam logic [FILL_W-1:0] FULL_PCT   = 7'd100;
	localparam logic [DIST_W-1:0] MIN_RESET  = 10'd4;
	localparam logic [DIST_W-1:0] MAX_RESET  = 10'd30;

	// Product (baseline - mean) * 100 fits in this many bits
	localparam int PROD_W = $clog2(1023 * 100 + 1);

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 1'b1;

	// Operand selection of the shared divider
	localparam logic [1:0] DSEL_MEAN = 2'd0;
	localparam logic [1:0] DSEL_BASE = 2'd1;
	localparam logic [1:0] DSEL_FILL = 2'd2;

	typedef struct packed {
		logic       load;       // store sample, clear accumulator
		logic       acc;        // add one ring entry to the sum
		logic       div_start;  // launch the divider
		logic [1:0] div_sel;    // which division
		logic       mean_load;  // capture the mean
		logic       cal_acc;    // accumulate mean into calibration sum
		logic       base_load;  // capture clamped baseline
		logic       fill_prep;  // decide direct fill, form product and span
		logic       fill_load;  // capture divided fill
		logic       out_load;   // move result into the output register
	} fle_cmd_t;

	typedef struct packed {
		logic sum_last;     // last ring entry being added
		logic div_done;     // quotient ready
		logic calib_done;   // baseline established
		logic cal_last;     // this mean completes calibration
		logic fill_direct;  // fill is 0% or 100% without division
		logic out_free;     // output register can take a word
	} fle_sts_t;

endpackage

`default_nettype wire

@@ sv/fill_level_estimator.sv @@
// fill_level_estimator: top level; joins the sequencer and the datapath.
// Depends on fle_pkg, fle_ctrl, fle_dp (which holds fle_div).
`default_nettype none

// Takes one distance sample per word and returns one result word for it: the
// mean of the last WINDOW samples (fewer right after reset), the fill level in
// percent and a calibrated flag. The first CALIB means are averaged into the
// empty baseline, clamped to max_distance and then raised to min_distance+1;
// until then the fill level reads 0. Samples are handled one at a time: each
// item sums the ring and divides for the mean, with one more division on the
// word that completes calibration and one when the fill lies strictly between
// 0% and 100%, all on the shared restoring divider (one bit per cycle, a
// quotient width of 17 at the default sizes); an item also waits while the
// previous word is still held in the output register. The ring is summed one
// entry per cycle. A finished word waits in the output register while the
// next sample is accepted.
// Configuration writes (index 0 min_distance, index 1 max_distance) take
// effect at once and belong between items.

module fill_level_estimator
	import fle_pkg::*;
#(
	parameter int WINDOW = 5,
	parameter int CALIB  = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIST_W-1:0]    cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_W-1:0]      s_tdata,   // [9:0] distance_cm
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [OUT_W-1:0]          m_tdata,   // [6:0] fill_percent, [16:7] mean_distance
	output logic                      m_tuser    // [0] calibrated
);

	fle_cmd_t cmd;
	fle_sts_t sts;

	fle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fle_dp #(
		.WINDOW(WINDOW),
		.CALIB (CALIB)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.distance  (s_tdata[DIST_W-1:0]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

@@ sv/fle_div.sv @@
// fle_div: restoring divider, one quotient bit per cycle.
// Uses fle_pkg for the divisor width.
`default_nettype none

module fle_div
	import fle_pkg::*;
#(
	parameter int DIV_W = 17
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_W-1:0]  dividend,
	input  wire logic [DIST_W-1:0] divisor,
	output logic                   done,
	output logic [DIV_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIST_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIST_W-1:0] dvs_q;

	logic [DIST_W:0]   trial;
	logic              fits;
	logic [DIST_W-1:0] rem_next;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial    = {rem_q, quo_q[DIV_W-1]};
		fits     = trial >= {1'b0, dvs_q};
		rem_next = fits ? DIST_W'(trial - {1'b0, dvs_q}) : trial[DIST_W-1:0];
	end

	// Control: busy flag, step counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ sv/fle_dp.sv @@
// fle_dp: datapath of the fill level estimator: sample ring, sums, calibration,
// baseline, fill computation and output register. Uses fle_pkg and fle_div.
`default_nettype none

module fle_dp
	import fle_pkg::*;
#(
	parameter int WINDOW = 5,
	parameter int CALIB  = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIST_W-1:0]    cfg_data,
	input  wire logic [DIST_W-1:0]    distance,
	input  wire logic                 m_tready,
	output logic                      m_tvalid,
	output logic [OUT_W-1:0]          m_tdata,
	output logic                      m_tuser,
	input  wire fle_cmd_t             cmd,
	output fle_sts_t                  sts
);

	localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = $clog2(WINDOW * 1023 + 1);
	localparam int CCNT_W = $clog2(CALIB + 1);
	localparam int CSUM_W = $clog2(CALIB * 1023 + 1);
	localparam int DIV_A  = (SUM_W > CSUM_W) ? SUM_W : CSUM_W;
	localparam int DIV_W  = (DIV_A > PROD_W) ? DIV_A : PROD_W;

	// Configuration registers
	logic [DIST_W-1:0] min_q;
	logic [DIST_W-1:0] max_q;

	// Sample ring and its pointers
	logic [DIST_W-1:0] ring_q [WINDOW];
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  k_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;

	// Calibration state
	logic              calib_done_q;
	logic [CCNT_W-1:0] calib_count_q;
	logic [CSUM_W-1:0] calib_sum_q;
	logic [DIST_W-1:0] base_q;

	// Per-item results
	logic [DIST_W-1:0] mean_q;
	logic [FILL_W-1:0] fill_q;
	logic [PROD_W-1:0] prod_q;
	logic [DIST_W-1:0] span_q;

	// Output register
	logic              m_tvalid_q;
	logic [FILL_W-1:0] out_fill_q;
	logic [DIST_W-1:0] out_mean_q;
	logic              out_cal_q;

	// Divider connections
	logic [DIV_W-1:0]  div_dividend;
	logic [DIST_W-1:0] div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quotient;

	logic [DIST_W-1:0] base_raw;
	logic [DIST_W-1:0] base_lo;
	logic [DIST_W-1:0] base_hi_clamped;
	logic [DIST_W-1:0] base_clamped;
	logic [DIST_W-1:0] diff;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RESET;
			max_q <= MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_DIST: min_q <= cfg_data;
				REG_MAX_DIST: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Store the sample into the ring
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ring_q[wp_q] <= distance;
		end
	end

	// Ring pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			count_q <= '0;
			k_q     <= '0;
		end else if (cmd.load) begin
			wp_q <= (wp_q == PTR_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
			if (count_q != CNT_W'(WINDOW)) begin
				count_q <= count_q + 1'b1;
			end
			k_q <= '0;
		end else if (cmd.acc && !sts.sum_last) begin
			k_q <= k_q + 1'b1;
		end
	end

	// Accumulate the held samples
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + SUM_W'(ring_q[k_q]);
		end
	end

	// Select divider operands
	always_comb begin
		unique case (cmd.div_sel)
			DSEL_MEAN: begin
				div_dividend = DIV_W'(sum_q);
				div_divisor  = DIST_W'(count_q);
			end
			DSEL_BASE: begin
				div_dividend = DIV_W'(calib_sum_q);
				div_divisor  = DIST_W'(calib_count_q);
			end
			DSEL_FILL: begin
				div_dividend = DIV_W'(prod_q);
				div_divisor  = span_q;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = DIST_W'(1);
			end
		endcase
	end

	fle_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Clamp the calibrated average: first to max, then raise to min + 1
	always_comb begin
		base_raw        = div_quotient[DIST_W-1:0];
		base_lo         = (min_q == DIST_MAX) ? DIST_MAX : min_q + 1'b1;
		base_hi_clamped = (base_raw > max_q) ? max_q : base_raw;
		base_clamped    = (base_hi_clamped < base_lo) ? base_lo : base_hi_clamped;
		diff            = base_q - mean_q;
	end

	// Calibration accumulation and baseline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_done_q  <= 1'b0;
			calib_count_q <= '0;
			calib_sum_q   <= '0;
			base_q        <= '0;
		end else begin
			if (cmd.cal_acc) begin
				calib_count_q <= calib_count_q + 1'b1;
				calib_sum_q   <= calib_sum_q + CSUM_W'(mean_q);
			end
			if (cmd.base_load) begin
				base_q       <= base_clamped;
				calib_done_q <= 1'b1;
			end
		end
	end

	// Mean, product, span and fill
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fill_q <= '0;
		end
		if (cmd.mean_load) begin
			mean_q <= div_quotient[DIST_W-1:0];
		end
		if (cmd.fill_prep) begin
			prod_q <= PROD_W'(PROD_W'(diff) * PROD_W'(FULL_PCT));
			span_q <= (base_q > min_q) ? base_q - min_q : DIST_W'(1);
			priority if (mean_q >= base_q) begin
				fill_q <= '0;
			end else if (mean_q <= min_q) begin
				fill_q <= FULL_PCT;
			end else begin
				// hold: the divider supplies the fill
				fill_q <= fill_q;
			end
		end
		if (cmd.fill_load) begin
			fill_q <= (div_quotient > DIV_W'(FULL_PCT)) ? FULL_PCT
			                                             : div_quotient[FILL_W-1:0];
		end
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_fill_q <= fill_q;
			out_mean_q <= mean_q;
			out_cal_q  <= calib_done_q;
		end
	end

	// Status back to the controller
	always_comb begin
		sts.sum_last    = CNT_W'(k_q) == count_q - 1'b1;
		sts.div_done    = div_done;
		sts.calib_done  = calib_done_q;
		sts.cal_last    = calib_count_q == CCNT_W'(CALIB - 1);
		sts.fill_direct = (mean_q >= base_q) || (mean_q <= min_q);
		sts.out_free    = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W - FILL_W - DIST_W){1'b0}}, out_mean_q, out_fill_q};
	assign m_tuser  = out_cal_q;

endmodule

`default_nettype wire

@@ sv/fle_ctrl.sv @@
// fle_ctrl: sequencer of the fill level estimator; steps one sample through
// summing, dividing, calibration and fill. Uses fle_pkg command/status types.
`default_nettype none

module fle_ctrl
	import fle_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire fle_sts_t sts,
	output fle_cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SUM       = 4'd1;
	localparam logic [3:0] ST_MEAN_GO   = 4'd2;
	localparam logic [3:0] ST_MEAN_WAIT = 4'd3;
	localparam logic [3:0] ST_CAL       = 4'd4;
	localparam logic [3:0] ST_BASE_GO   = 4'd5;
	localparam logic [3:0] ST_BASE_WAIT = 4'd6;
	localparam logic [3:0] ST_FILL      = 4'd7;
	localparam logic [3:0] ST_FILL_GO   = 4'd8;
	localparam logic [3:0] ST_FILL_WAIT = 4'd9;
	localparam logic [3:0] ST_OUT       = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.acc = 1'b1;
				if (sts.sum_last) begin
					state_d = ST_MEAN_GO;
				end
			end
			ST_MEAN_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_MEAN;
				state_d       = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (sts.div_done) begin
					cmd.mean_load = 1'b1;
					state_d       = sts.calib_done ? ST_FILL : ST_CAL;
				end
			end
			ST_CAL: begin
				cmd.cal_acc = 1'b1;
				state_d     = sts.cal_last ? ST_BASE_GO : ST_OUT;
			end
			ST_BASE_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_BASE;
				state_d       = ST_BASE_WAIT;
			end
			ST_BASE_WAIT: begin
				cmd.div_sel = DSEL_BASE;
				if (sts.div_done) begin
					cmd.base_load = 1'b1;
					state_d       = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_prep = 1'b1;
				state_d       = sts.fill_direct ? ST_OUT : ST_FILL_GO;
			end
			ST_FILL_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_FILL;
				state_d       = ST_FILL_WAIT;
			end
			ST_FILL_WAIT: begin
				cmd.div_sel = DSEL_FILL;
				if (sts.div_done) begin
					cmd.fill_load = 1'b1;
					state_d       = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire
